@@ rtl/mfq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and reset values for the three-level run-queue scheduler.
// No dependencies; every other file takes names from here, by scope or by import.
package mfq_pkg;

	// Field widths of the channel words
	localparam int ACTION_W   = 2;
	localparam int THREAD_W   = 8;
	localparam int LEVEL_W    = 2;
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 24;
	localparam int PERIOD_W   = 8;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int NUM_LEVELS = 3;

	// Default sizing
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_REQUEUE  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

	// Level codes
	localparam logic [LEVEL_W-1:0] LVL_HIGH   = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_LOW    = 2'd2;

	// Requeue kinds; any other code counts as preempted
	localparam logic [KIND_W-1:0] KIND_YIELD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INVERT = 2'd1;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_HIGH_RUN_LIMIT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_RUN_LIMIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOOST_PERIOD     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_QUANTUM     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_QUANTUM   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LOW_QUANTUM      = 3'd5;

	// Register reset values
	localparam logic [TIME_W-1:0]   RST_HIGH_RUN_LIMIT   = 24'd100000;
	localparam logic [TIME_W-1:0]   RST_NORMAL_RUN_LIMIT = 24'd200000;
	localparam logic [PERIOD_W-1:0] RST_BOOST_PERIOD     = 8'd10;
	localparam logic [TIME_W-1:0]   RST_HIGH_QUANTUM     = 24'd50000;
	localparam logic [TIME_W-1:0]   RST_NORMAL_QUANTUM   = 24'd100000;
	localparam logic [TIME_W-1:0]   RST_LOW_QUANTUM      = 24'd1500000;

endpackage

@@ rtl/mfq_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces: scheduler request, scheduler result and register write.
// Depends on mfq_pkg for field widths.

interface mfq_req_if;
	logic                            valid;
	logic                            ready;
	logic [mfq_pkg::ACTION_W-1:0]    action;
	logic [mfq_pkg::THREAD_W-1:0]    thread_id;
	logic [mfq_pkg::LEVEL_W-1:0]     thread_level;
	logic [mfq_pkg::KIND_W-1:0]      requeue_kind;
	logic [mfq_pkg::TIME_W-1:0]      run_total;

	modport source (output valid, action, thread_id, thread_level, requeue_kind, run_total,
		input ready);
	modport sink (input valid, action, thread_id, thread_level, requeue_kind, run_total,
		output ready);
endinterface

interface mfq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            found;
	logic [mfq_pkg::THREAD_W-1:0]    out_thread;
	logic [mfq_pkg::LEVEL_W-1:0]     out_level;
	logic [mfq_pkg::TIME_W-1:0]      quantum_us;
	logic                            total_cleared;
	logic                            boosted;
	logic                            queue_full;

	modport source (output valid, found, out_thread, out_level, quantum_us, total_cleared,
		boosted, queue_full, input ready);
	modport sink (input valid, found, out_thread, out_level, quantum_us, total_cleared,
		boosted, queue_full, output ready);
endinterface

interface mfq_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mfq_pkg::REG_IDX_W-1:0]   index;
	logic [mfq_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/multilevel_feedback_queue_scheduler.sv @@
`timescale 1ns / 1ps
// Three-level feedback run-queue scheduler: control sequencer, queue pointers and registers.
// Depends on mfq_pkg, mfq_ifs (channel interfaces) and mfq_store (queue memory).
//
//   port   role     handshake      word
//   req    sink     valid/ready    action, thread_id, thread_level, requeue_kind, run_total
//   rsp    source   valid/ready    found, out_thread, out_level, quantum_us, total_cleared,
//                                  boosted, queue_full
//   cfg    sink     valid/ready    index, data (ready always high)
//
// Requeue, dispatch and a tick without boost pass through the execute state, then the finish state.
// A boosting tick moves low entries one by one before the finish state: each move is a read of the
// low queue then a write into the high queue through the one memory port pair.
// One word is worked at a time; the next is accepted once the result sits in the output
// register, which holds it until taken. Reset clears pointers and counts at once; the
// memory needs no clearing pass.
module multilevel_feedback_queue_scheduler #(
	parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = mfq_pkg::ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mfq_req_if.sink   req,
	mfq_rsp_if.source rsp,
	mfq_cfg_if.sink   cfg
);

	localparam int HW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SW  = CW + 1;
	localparam int IDW = ID_BITS;
	localparam int TW  = mfq_pkg::THREAD_W;
	localparam int PW  = mfq_pkg::PERIOD_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_BRD  = 3'd2;
	localparam logic [2:0] ST_BWR  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;

	// Queue pointers and tick counter
	logic [HW-1:0] hd_q  [mfq_pkg::NUM_LEVELS];
	logic [CW-1:0] cnt_q [mfq_pkg::NUM_LEVELS];
	logic [PW-1:0] tick_q;

	// Configuration registers
	logic [mfq_pkg::TIME_W-1:0] hi_lim_q, nrm_lim_q, hi_quant_q, nrm_quant_q, lo_quant_q;
	logic [PW-1:0]              period_q;

	// Latched request word
	logic [mfq_pkg::ACTION_W-1:0] it_act_q;
	logic [TW-1:0]                it_id_q;
	logic [mfq_pkg::LEVEL_W-1:0]  it_lvl_q;
	logic [mfq_pkg::KIND_W-1:0]   it_kind_q;
	logic [mfq_pkg::TIME_W-1:0]   it_total_q;

	// Staged result
	logic                         res_found_q, res_clr_q, res_boost_q, res_full_q;
	logic [mfq_pkg::LEVEL_W-1:0]  res_lvl_q;
	logic [mfq_pkg::TIME_W-1:0]   res_quant_q;

	// Output register
	logic                         out_vld_q, out_found_q, out_clr_q, out_boost_q, out_full_q;
	logic [TW-1:0]                out_thread_q;
	logic [mfq_pkg::LEVEL_W-1:0]  out_lvl_q;
	logic [mfq_pkg::TIME_W-1:0]   out_quant_q;

	// Memory ports
	logic                         wr_en, rd_en;
	logic [mfq_pkg::LEVEL_W-1:0]  wr_lvl, rd_lvl;
	logic [HW-1:0]                wr_slot, rd_slot;
	logic [IDW-1:0]               wr_data, rd_data;

	logic                         req_acc, out_free, fin_go;
	logic [mfq_pkg::LEVEL_W-1:0]  lvl_eff, target, dq;
	logic                         demote, push_ok, disp_found, boost_hit, brd_move, brd_full;
	logic [PW:0]                  tick_next;
	logic [mfq_pkg::TIME_W-1:0]   disp_quant;

	function automatic logic [HW-1:0] slot_tail(input logic [HW-1:0] h, input logic [CW-1:0] c);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(c);
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return s[HW-1:0];
	endfunction

	function automatic logic [HW-1:0] hd_inc(input logic [HW-1:0] h);
		return (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign fin_go    = (state_q == ST_FIN) && out_free;

	// Decode the latched word: requeue target, dispatch pick, tick compare, boost move checks
	always_comb begin
		lvl_eff = (it_lvl_q > mfq_pkg::LVL_LOW) ? mfq_pkg::LVL_LOW : it_lvl_q;
		demote  = 1'b0;
		case (it_kind_q)
			mfq_pkg::KIND_YIELD:  target = lvl_eff;
			mfq_pkg::KIND_INVERT: target = mfq_pkg::LVL_HIGH;
			default: begin
				target = lvl_eff;
				if (lvl_eff == mfq_pkg::LVL_HIGH && it_total_q >= hi_lim_q) begin
					target = mfq_pkg::LVL_NORMAL;
					demote = 1'b1;
				end else if (lvl_eff == mfq_pkg::LVL_NORMAL && it_total_q >= nrm_lim_q) begin
					target = mfq_pkg::LVL_LOW;
					demote = 1'b1;
				end
			end
		endcase
		push_ok = (cnt_q[target] != CW'(QUEUE_DEPTH));

		disp_found = 1'b1;
		if (cnt_q[mfq_pkg::LVL_HIGH] != '0) begin
			dq         = mfq_pkg::LVL_HIGH;
			disp_quant = hi_quant_q;
		end else if (cnt_q[mfq_pkg::LVL_NORMAL] != '0) begin
			dq         = mfq_pkg::LVL_NORMAL;
			disp_quant = nrm_quant_q;
		end else if (cnt_q[mfq_pkg::LVL_LOW] != '0) begin
			dq         = mfq_pkg::LVL_LOW;
			disp_quant = lo_quant_q;
		end else begin
			dq         = mfq_pkg::LVL_HIGH;
			disp_quant = '0;
			disp_found = 1'b0;
		end

		tick_next = {1'b0, tick_q} + 1'b1;
		boost_hit = (tick_next >= {1'b0, period_q});

		brd_move = (cnt_q[mfq_pkg::LVL_LOW] != '0) &&
			(cnt_q[mfq_pkg::LVL_HIGH] != CW'(QUEUE_DEPTH));
		brd_full = (cnt_q[mfq_pkg::LVL_LOW] != '0) &&
			(cnt_q[mfq_pkg::LVL_HIGH] == CW'(QUEUE_DEPTH));
	end

	// Drive memory ports; reads and writes never hit the same entry in flight
	always_comb begin
		wr_en   = 1'b0;
		wr_lvl  = target;
		wr_slot = slot_tail(hd_q[target], cnt_q[target]);
		wr_data = IDW'(it_id_q);
		rd_en   = 1'b0;
		rd_lvl  = dq;
		rd_slot = hd_q[dq];
		case (state_q)
			ST_EXEC: begin
				wr_en = (it_act_q == mfq_pkg::ACT_REQUEUE) && push_ok;
				rd_en = (it_act_q == mfq_pkg::ACT_DISPATCH) && disp_found;
			end
			ST_BRD: begin
				rd_en   = brd_move;
				rd_lvl  = mfq_pkg::LVL_LOW;
				rd_slot = hd_q[mfq_pkg::LVL_LOW];
			end
			ST_BWR: begin
				wr_en   = 1'b1;
				wr_lvl  = mfq_pkg::LVL_HIGH;
				wr_slot = slot_tail(hd_q[mfq_pkg::LVL_HIGH], cnt_q[mfq_pkg::LVL_HIGH]);
				wr_data = rd_data;
			end
			default: ;
		endcase
	end

	mfq_store #(
		.DEPTH (QUEUE_DEPTH),
		.IDW   (IDW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_lvl  (wr_lvl),
		.wr_slot (wr_slot),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_lvl  (rd_lvl),
		.rd_slot (rd_slot),
		.rd_data (rd_data)
	);

	// Sequencer, pointers, registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < mfq_pkg::NUM_LEVELS; i++) begin
				hd_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
			tick_q      <= '0;
			out_vld_q   <= 1'b0;
			hi_lim_q    <= mfq_pkg::RST_HIGH_RUN_LIMIT;
			nrm_lim_q   <= mfq_pkg::RST_NORMAL_RUN_LIMIT;
			period_q    <= mfq_pkg::RST_BOOST_PERIOD;
			hi_quant_q  <= mfq_pkg::RST_HIGH_QUANTUM;
			nrm_quant_q <= mfq_pkg::RST_NORMAL_QUANTUM;
			lo_quant_q  <= mfq_pkg::RST_LOW_QUANTUM;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					mfq_pkg::REG_HIGH_RUN_LIMIT:   hi_lim_q    <= cfg.data;
					mfq_pkg::REG_NORMAL_RUN_LIMIT: nrm_lim_q   <= cfg.data;
					mfq_pkg::REG_BOOST_PERIOD:     period_q    <= cfg.data[PW-1:0];
					mfq_pkg::REG_HIGH_QUANTUM:     hi_quant_q  <= cfg.data;
					mfq_pkg::REG_NORMAL_QUANTUM:   nrm_quant_q <= cfg.data;
					mfq_pkg::REG_LOW_QUANTUM:      lo_quant_q  <= cfg.data;
					default: ;
				endcase
			end

			if (fin_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (it_act_q)
						mfq_pkg::ACT_REQUEUE: begin
							if (push_ok) begin
								cnt_q[target] <= cnt_q[target] + 1'b1;
							end
						end
						mfq_pkg::ACT_DISPATCH: begin
							if (disp_found) begin
								hd_q[dq]  <= hd_inc(hd_q[dq]);
								cnt_q[dq] <= cnt_q[dq] - 1'b1;
							end
						end
						mfq_pkg::ACT_TICK: begin
							if (boost_hit) begin
								tick_q  <= '0;
								state_q <= ST_BRD;
							end else begin
								tick_q <= tick_next[PW-1:0];
							end
						end
						default: ;
					endcase
				end
				ST_BRD: begin
					if (brd_move) begin
						hd_q[mfq_pkg::LVL_LOW]  <= hd_inc(hd_q[mfq_pkg::LVL_LOW]);
						cnt_q[mfq_pkg::LVL_LOW] <= cnt_q[mfq_pkg::LVL_LOW] - 1'b1;
						state_q                 <= ST_BWR;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_BWR: begin
					cnt_q[mfq_pkg::LVL_HIGH] <= cnt_q[mfq_pkg::LVL_HIGH] + 1'b1;
					state_q                  <= ST_BRD;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the request, stage the result, load the output register
	always_ff @(posedge clk) begin
		if (req_acc) begin
			it_act_q   <= req.action;
			it_id_q    <= req.thread_id;
			it_lvl_q   <= req.thread_level;
			it_kind_q  <= req.requeue_kind;
			it_total_q <= req.run_total;
		end

		if (state_q == ST_EXEC) begin
			res_found_q <= 1'b0;
			res_lvl_q   <= '0;
			res_quant_q <= '0;
			res_clr_q   <= 1'b0;
			res_boost_q <= 1'b0;
			res_full_q  <= 1'b0;
			case (it_act_q)
				mfq_pkg::ACT_REQUEUE: begin
					res_lvl_q  <= target;
					res_clr_q  <= demote && push_ok;
					res_full_q <= !push_ok;
				end
				mfq_pkg::ACT_DISPATCH: begin
					res_found_q <= disp_found;
					res_lvl_q   <= disp_found ? dq : '0;
					res_quant_q <= disp_quant;
				end
				mfq_pkg::ACT_TICK: res_boost_q <= boost_hit;
				default: ;
			endcase
		end

		if (state_q == ST_BRD && brd_full) begin
			res_full_q <= 1'b1;
		end

		if (fin_go) begin
			out_found_q  <= res_found_q;
			out_thread_q <= res_found_q ? TW'(rd_data) : '0;
			out_lvl_q    <= res_lvl_q;
			out_quant_q  <= res_quant_q;
			out_clr_q    <= res_clr_q;
			out_boost_q  <= res_boost_q;
			out_full_q   <= res_full_q;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.found         = out_found_q;
	assign rsp.out_thread    = out_thread_q;
	assign rsp.out_level     = out_lvl_q;
	assign rsp.quantum_us    = out_quant_q;
	assign rsp.total_cleared = out_clr_q;
	assign rsp.boosted       = out_boost_q;
	assign rsp.queue_full    = out_full_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[mfq_pkg::LVL_HIGH] <= CW'(QUEUE_DEPTH) &&
		cnt_q[mfq_pkg::LVL_NORMAL] <= CW'(QUEUE_DEPTH) &&
		cnt_q[mfq_pkg::LVL_LOW] <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_boost_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BWR |-> cnt_q[mfq_pkg::LVL_HIGH] < CW'(QUEUE_DEPTH))
		else $error("boost move into a full high queue");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == ST_EXEC)
		else $error("accepted word not taken into execution");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the finish step");
`endif

endmodule

@@ rtl/mfq_store.sv @@
`timescale 1ns / 1ps
// Run-queue storage: one memory holding the three FIFOs, one write and one read port.
// Depends on mfq_pkg for the level count and widths.
module mfq_store #(
	parameter int DEPTH = mfq_pkg::QUEUE_DEPTH_DEF,
	parameter int IDW   = mfq_pkg::ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [mfq_pkg::LEVEL_W-1:0]  wr_lvl,
	input  logic [$clog2(DEPTH)-1:0]     wr_slot,
	input  logic [IDW-1:0]               wr_data,
	input  logic                         rd_en,
	input  logic [mfq_pkg::LEVEL_W-1:0]  rd_lvl,
	input  logic [$clog2(DEPTH)-1:0]     rd_slot,
	output logic [IDW-1:0]               rd_data
);

	logic [IDW-1:0] fifo_mem [mfq_pkg::NUM_LEVELS][DEPTH];
	logic [IDW-1:0] rd_data_q;

	// Write one id
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_mem[wr_lvl][wr_slot] <= wr_data;
		end
	end

	// Registered read, held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= fifo_mem[rd_lvl][rd_slot];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ tb/sv/multilevel_feedback_queue_scheduler_test.sv @@
`timescale 1ns / 1ps
// Self-checking test of the three-level feedback run-queue scheduler: requests go in
// through paced bursts, every decision is predicted at acceptance and checked in order.
// Depends on mfq_pkg, mfq_ifs and the scheduler RTL.
module multilevel_feedback_queue_scheduler_test;
	import mfq_pkg::*;

	localparam int QDEPTH       = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 6;
	localparam int DRAIN_CYCLES = 60;

	// Codes that the package leaves unnamed
	localparam logic [ACTION_W-1:0]  ACT_UNUSED   = 2'd3;
	localparam logic [LEVEL_W-1:0]   LVL_UNUSED   = 2'd3;
	localparam logic [KIND_W-1:0]    KIND_PREEMPT = 2'd2;
	localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B  = 3'd7;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [THREAD_W-1:0] thread_id;
		logic [LEVEL_W-1:0]  thread_level;
		logic [KIND_W-1:0]   requeue_kind;
		logic [TIME_W-1:0]   run_total;
	} sched_request_t;

	typedef struct packed {
		logic                found;
		logic [THREAD_W-1:0] out_thread;
		logic [LEVEL_W-1:0]  out_level;
		logic [TIME_W-1:0]   quantum_us;
		logic                total_cleared;
		logic                boosted;
		logic                queue_full;
	} decision_t;

	logic clk;
	logic arst_n;

	mfq_req_if req_if();
	mfq_rsp_if rsp_if();
	mfq_cfg_if cfg_if();

	multilevel_feedback_queue_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Scheduler shadow: run queues, tick count and registers
	logic [THREAD_W-1:0] runq_mem [NUM_LEVELS][QDEPTH];
	int                  runq_head [NUM_LEVELS];
	int                  runq_count [NUM_LEVELS];
	logic [PERIOD_W-1:0] tick_cnt;
	logic [TIME_W-1:0]   lim_high, lim_normal;
	logic [PERIOD_W-1:0] boost_per;
	logic [TIME_W-1:0]   quant_high, quant_normal, quant_low;

	decision_t decisions_due [$];
	int        mismatches;
	int        cycle_count;
	int        burst_left;
	int        stall_mode;
	int        stall_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Append an id to a run queue; refuse when the queue is full
	function automatic bit runq_push(input int q, input logic [THREAD_W-1:0] id);
		if (runq_count[q] >= QDEPTH)
			return 1'b0;
		runq_mem[q][(runq_head[q] + runq_count[q]) % QDEPTH] = id;
		runq_count[q]++;
		return 1'b1;
	endfunction

	function automatic logic [THREAD_W-1:0] runq_pop(input int q);
		logic [THREAD_W-1:0] id;
		id = runq_mem[q][runq_head[q]];
		runq_head[q] = (runq_head[q] + 1) % QDEPTH;
		runq_count[q]--;
		return id;
	endfunction

	// Advance the shadow by one request and return the decision it causes
	function automatic decision_t schedule_step(input sched_request_t rq);
		decision_t           d;
		logic [LEVEL_W-1:0]  lvl;
		logic [LEVEL_W-1:0]  target;
		logic [PERIOD_W:0]   next_tick;
		logic [THREAD_W-1:0] moved;
		bit                  moving;
		d = '0;
		lvl = (rq.thread_level > LVL_LOW) ? LVL_LOW : rq.thread_level;
		case (rq.action)
		ACT_REQUEUE: begin
			target = lvl;
			if (rq.requeue_kind == KIND_YIELD) begin
				target = lvl;
			end else if (rq.requeue_kind == KIND_INVERT) begin
				target = LVL_HIGH;
			end else if (lvl == LVL_HIGH && rq.run_total >= lim_high) begin
				target = LVL_NORMAL;
				d.total_cleared = 1'b1;
			end else if (lvl == LVL_NORMAL && rq.run_total >= lim_normal) begin
				target = LVL_LOW;
				d.total_cleared = 1'b1;
			end
			d.out_level = target;
			if (!runq_push(int'(target), rq.thread_id)) begin
				d.queue_full = 1'b1;
				d.total_cleared = 1'b0;
			end
		end
		ACT_DISPATCH: begin
			for (int q = 0; q < NUM_LEVELS; q++) begin
				if (!d.found && runq_count[q] != 0) begin
					d.found = 1'b1;
					d.out_thread = runq_pop(q);
					d.out_level = LEVEL_W'(q);
					if (d.out_level == LVL_HIGH)
						d.quantum_us = quant_high;
					else if (d.out_level == LVL_NORMAL)
						d.quantum_us = quant_normal;
					else
						d.quantum_us = quant_low;
				end
			end
		end
		ACT_TICK: begin
			next_tick = {1'b0, tick_cnt} + 1'b1;
			if (next_tick >= {1'b0, boost_per}) begin
				d.boosted = 1'b1;
				tick_cnt = '0;
				// Move low entries to high in order while high has room
				moving = 1'b1;
				while (moving && runq_count[LVL_LOW] != 0) begin
					if (runq_count[LVL_HIGH] >= QDEPTH) begin
						d.queue_full = 1'b1;
						moving = 1'b0;
					end else begin
						moved = runq_pop(int'(LVL_LOW));
						void'(runq_push(int'(LVL_HIGH), moved));
					end
				end
			end else begin
				tick_cnt = next_tick[PERIOD_W-1:0];
			end
		end
		default: ;
		endcase
		return d;
	endfunction

	// Track register writes, predict accepted requests, check taken decisions
	always @(posedge clk) begin : monitor
		sched_request_t rq;
		decision_t      got;
		decision_t      want;
		cycle_count++;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
				REG_HIGH_RUN_LIMIT:   lim_high = cfg_if.data;
				REG_NORMAL_RUN_LIMIT: lim_normal = cfg_if.data;
				REG_BOOST_PERIOD:     boost_per = cfg_if.data[PERIOD_W-1:0];
				REG_HIGH_QUANTUM:     quant_high = cfg_if.data;
				REG_NORMAL_QUANTUM:   quant_normal = cfg_if.data;
				REG_LOW_QUANTUM:      quant_low = cfg_if.data;
				default: ;
				endcase
			end
			if (req_if.valid && req_if.ready) begin
				rq.action = req_if.action;
				rq.thread_id = req_if.thread_id;
				rq.thread_level = req_if.thread_level;
				rq.requeue_kind = req_if.requeue_kind;
				rq.run_total = req_if.run_total;
				decisions_due.push_back(schedule_step(rq));
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got.found = rsp_if.found;
				got.out_thread = rsp_if.out_thread;
				got.out_level = rsp_if.out_level;
				got.quantum_us = rsp_if.quantum_us;
				got.total_cleared = rsp_if.total_cleared;
				got.boosted = rsp_if.boosted;
				got.queue_full = rsp_if.queue_full;
				if (decisions_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: decision word with none pending", $realtime);
				end else begin
					want = decisions_due.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch expected found=%0d thread=%0d level=%0d",
								$realtime, want.found, want.out_thread, want.out_level,
								" quantum=%0d cleared=%0d boosted=%0d full=%0d,",
								want.quantum_us, want.total_cleared, want.boosted,
								want.queue_full,
								" got found=%0d thread=%0d level=%0d quantum=%0d",
								got.found, got.out_thread, got.out_level, got.quantum_us,
								" cleared=%0d boosted=%0d full=%0d",
								got.total_cleared, got.boosted, got.queue_full);
					end
				end
			end
		end
	end

	// Stall the result channel on a pattern that changes mode now and then
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end else begin
			stall_left--;
		end
		case (stall_mode)
		0: rsp_if.ready <= 1'b1;
		1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
		2: rsp_if.ready <= ($urandom_range(0, 4) == 0);
		default: rsp_if.ready <= (stall_left % 12 == 0);
		endcase
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[multilevel_feedback_queue_scheduler] ERROR");
		$finish;
	end

	function automatic sched_request_t make_request(input logic [ACTION_W-1:0] action,
		input logic [THREAD_W-1:0] id, input logic [LEVEL_W-1:0] lvl,
		input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] total);
		sched_request_t rq;
		rq.action = action;
		rq.thread_id = id;
		rq.thread_level = lvl;
		rq.requeue_kind = kind;
		rq.run_total = total;
		return rq;
	endfunction

	// Run totals cluster around the demotion limit of the given level (normal's for any but high)
	function automatic logic [TIME_W-1:0] pick_run_total(input logic [LEVEL_W-1:0] lvl);
		logic [TIME_W-1:0] lim;
		logic [31:0]       r;
		lim = (lvl == LVL_HIGH) ? lim_high : lim_normal;
		r = $urandom;
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return (lim == '0) ? lim : lim - 1'b1;
		3: return lim;
		4: return (lim == '1) ? lim : lim + 1'b1;
		default: return r[TIME_W-1:0];
		endcase
	endfunction

	function automatic sched_request_t random_request();
		sched_request_t rq;
		int             pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			rq.action = ACT_REQUEUE;
		else if (pick < 78)
			rq.action = ACT_DISPATCH;
		else if (pick < 97)
			rq.action = ACT_TICK;
		else
			rq.action = ACT_UNUSED;
		rq.thread_id = THREAD_W'($urandom_range(0, 255));
		rq.thread_level = ($urandom_range(0, 9) == 0) ? LVL_UNUSED
			: LEVEL_W'($urandom_range(0, 2));
		rq.requeue_kind = KIND_W'($urandom_range(0, 3));
		rq.run_total = pick_run_total(rq.thread_level);
		return rq;
	endfunction

	// Send one request word, in bursts with random gaps between them
	task automatic issue_request(input sched_request_t rq);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.action <= rq.action;
		req_if.thread_id <= rq.thread_id;
		req_if.thread_level <= rq.thread_level;
		req_if.requeue_kind <= rq.requeue_kind;
		req_if.run_total <= rq.run_total;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// Hold off the sender until every pending decision has been taken
	task automatic wait_for_decisions();
		@(negedge clk);
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (decisions_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Write the whole register set while the block is idle
	task automatic program_registers(input logic [TIME_W-1:0] hl, input logic [TIME_W-1:0] nl,
		input logic [CFG_DATA_W-1:0] bp, input logic [TIME_W-1:0] hq,
		input logic [TIME_W-1:0] nq, input logic [TIME_W-1:0] lq);
		logic [31:0] r;
		wait_for_decisions();
		r = $urandom;
		write_register(REG_HIGH_RUN_LIMIT, hl);
		write_register(REG_NORMAL_RUN_LIMIT, nl);
		write_register(REG_BOOST_PERIOD, bp);
		write_register(REG_HIGH_QUANTUM, hq);
		write_register(REG_NORMAL_QUANTUM, nq);
		write_register(REG_LOW_QUANTUM, lq);
		// Spare indexes must leave every register alone
		write_register(r[0] ? REG_SPARE_A : REG_SPARE_B, r[31:8]);
	endtask

	// Mostly mixed traffic, with runs that fill a queue, flood high before a boost, or drain
	task automatic run_mixed(input int n);
		int sent;
		int pick;
		int len;
		int ticks;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = $urandom_range(5, 20);
				repeat (len) issue_request(random_request());
				sent += len;
				if ($urandom_range(0, 9) == 0)
					wait_for_decisions();
			end else if (pick < 75) begin
				len = $urandom_range(15, 19);
				pick = $urandom_range(0, 2);
				repeat (len) issue_request(make_request(ACT_REQUEUE,
					THREAD_W'($urandom_range(0, 255)), LEVEL_W'(pick), KIND_YIELD,
					pick_run_total(LEVEL_W'(pick))));
				sent += len;
			end else if (pick < 85) begin
				repeat (17) issue_request(make_request(ACT_REQUEUE,
					THREAD_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 3)),
					KIND_INVERT, TIME_W'($urandom)));
				repeat (3) issue_request(make_request(ACT_REQUEUE,
					THREAD_W'($urandom_range(0, 255)), LVL_LOW, KIND_YIELD,
					TIME_W'($urandom)));
				ticks = (boost_per == 0) ? 1 : ((boost_per > 3) ? 2 : int'(boost_per));
				repeat (ticks) issue_request(make_request(ACT_TICK,
					THREAD_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 3)),
					KIND_W'($urandom_range(0, 3)), TIME_W'($urandom)));
				sent += 20 + ticks;
			end else begin
				len = $urandom_range(8, 20);
				repeat (len) issue_request(make_request(ACT_DISPATCH,
					THREAD_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 3)),
					KIND_W'($urandom_range(0, 3)), TIME_W'($urandom)));
				sent += len;
			end
		end
	endtask

	// Dispatch from empty queues and an unused action code
	task automatic test_empty_and_unused();
		issue_request(make_request(ACT_DISPATCH, '0, LVL_HIGH, KIND_YIELD, '0));
		issue_request(make_request(ACT_UNUSED, '1, LVL_UNUSED, KIND_UNUSED, '1));
	endtask

	// File threads by every kind around the reset limits, then drain in priority order
	task automatic test_requeue_kinds();
		issue_request(make_request(ACT_REQUEUE, 8'd0, LVL_HIGH, KIND_YIELD, '0));
		issue_request(make_request(ACT_REQUEUE, 8'd255, LVL_NORMAL, KIND_INVERT, '1));
		issue_request(make_request(ACT_REQUEUE, 8'd17, LVL_HIGH, KIND_PREEMPT,
			RST_HIGH_RUN_LIMIT - 1'b1));
		issue_request(make_request(ACT_REQUEUE, 8'd34, LVL_HIGH, KIND_PREEMPT,
			RST_HIGH_RUN_LIMIT));
		issue_request(make_request(ACT_REQUEUE, 8'd51, LVL_NORMAL, KIND_PREEMPT,
			RST_NORMAL_RUN_LIMIT));
		issue_request(make_request(ACT_REQUEUE, 8'd68, LVL_NORMAL, KIND_PREEMPT,
			RST_NORMAL_RUN_LIMIT - 1'b1));
		issue_request(make_request(ACT_REQUEUE, 8'd85, LVL_LOW, KIND_PREEMPT, '1));
		issue_request(make_request(ACT_REQUEUE, 8'd102, LVL_UNUSED, KIND_YIELD, '0));
		issue_request(make_request(ACT_REQUEUE, 8'd119, LVL_HIGH, KIND_UNUSED, '1));
		issue_request(make_request(ACT_REQUEUE, 8'd136, LVL_NORMAL, KIND_YIELD, '1));
		repeat (10) issue_request(make_request(ACT_DISPATCH, '0, LVL_HIGH, KIND_YIELD, '0));
	endtask

	// Count ticks up to a short boost period and watch low threads return at high
	task automatic test_boost();
		wait_for_decisions();
		write_register(REG_BOOST_PERIOD, 24'd2);
		issue_request(make_request(ACT_REQUEUE, 8'h5A, LVL_LOW, KIND_YIELD, '0));
		issue_request(make_request(ACT_REQUEUE, 8'hA5, LVL_LOW, KIND_YIELD, '0));
		issue_request(make_request(ACT_TICK, '0, LVL_HIGH, KIND_YIELD, '0));
		issue_request(make_request(ACT_TICK, '1, LVL_UNUSED, KIND_UNUSED, '1));
		repeat (2) issue_request(make_request(ACT_DISPATCH, '0, LVL_HIGH, KIND_YIELD, '0));
	endtask

	task automatic test_default_settings();
		program_registers(RST_HIGH_RUN_LIMIT, RST_NORMAL_RUN_LIMIT,
			CFG_DATA_W'(RST_BOOST_PERIOD),
			RST_HIGH_QUANTUM, RST_NORMAL_QUANTUM, RST_LOW_QUANTUM);
		run_mixed(90);
	endtask

	// Zero limits demote every preemption from high or normal; a zero period boosts on every tick
	task automatic test_minimum_settings();
		program_registers('0, '0, '0, 24'd1, 24'd1, 24'd1);
		run_mixed(90);
	endtask

	task automatic test_maximum_settings();
		logic [31:0] r;
		r = $urandom;
		program_registers('1, '1, {r[15:0], 8'hFF}, '1, '1, '1);
		run_mixed(80);
	endtask

	task automatic test_random_settings();
		logic [31:0] r;
		repeat (3) begin
			r = $urandom;
			program_registers(r[0] ? TIME_W'($urandom_range(0, 300)) : TIME_W'($urandom),
				r[1] ? TIME_W'($urandom_range(0, 300)) : TIME_W'($urandom),
				{r[31:16], 8'($urandom_range(1, 5))},
				TIME_W'($urandom_range(1, 24'hFFFFFF)),
				TIME_W'($urandom_range(1, 24'hFFFFFF)),
				TIME_W'($urandom_range(1, 24'hFFFFFF)));
			run_mixed(50);
		end
	endtask

	// Boost on every tick so a full high queue leaves low entries behind
	task automatic test_boost_overflow();
		program_registers(RST_HIGH_RUN_LIMIT, RST_NORMAL_RUN_LIMIT, 24'd1,
			RST_HIGH_QUANTUM, RST_NORMAL_QUANTUM, RST_LOW_QUANTUM);
		run_mixed(60);
	endtask

	initial begin
		// Drive every input to a known value and reset the shadow
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_REQUEUE;
		req_if.thread_id = '0;
		req_if.thread_level = LVL_HIGH;
		req_if.requeue_kind = KIND_YIELD;
		req_if.run_total = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_HIGH_RUN_LIMIT;
		cfg_if.data = '0;
		mismatches = 0;
		cycle_count = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		for (int q = 0; q < NUM_LEVELS; q++) begin
			runq_head[q] = 0;
			runq_count[q] = 0;
			for (int i = 0; i < QDEPTH; i++)
				runq_mem[q][i] = '0;
		end
		tick_cnt = '0;
		lim_high = RST_HIGH_RUN_LIMIT;
		lim_normal = RST_NORMAL_RUN_LIMIT;
		boost_per = RST_BOOST_PERIOD;
		quant_high = RST_HIGH_QUANTUM;
		quant_normal = RST_NORMAL_QUANTUM;
		quant_low = RST_LOW_QUANTUM;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_and_unused();
		test_requeue_kinds();
		test_boost();
		test_default_settings();
		test_minimum_settings();
		test_maximum_settings();
		test_random_settings();
		test_boost_overflow();

		// Drain the pipeline and give any stray word time to show up
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (decisions_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && decisions_due.size() == 0)
			$display("[multilevel_feedback_queue_scheduler] OK");
		else
			$display("[multilevel_feedback_queue_scheduler] ERROR");
		$finish;
	end

endmodule
